/* src/a51_pkg.sv */
// ----------------------------------------------------------------------------
// a51_pkg
// Shared types and constants for the A5/1 keystream unit.
// ----------------------------------------------------------------------------
package a51_pkg;

    localparam int KEY_BITS      = 64;
    localparam int FRAME_BITS    = 22;
    localparam int LOAD_BITS     = KEY_BITS + FRAME_BITS;
    localparam int KEYSTREAM_LEN = 228;
    localparam int WARMUP_CLOCKS = 100;
    localparam int POS_W         = 8;
    localparam int CNT_W         = 8;

    localparam int R1_W = 19;
    localparam int R2_W = 22;
    localparam int R3_W = 23;

    localparam int R1_CLK = 8;
    localparam int R2_CLK = 10;
    localparam int R3_CLK = 10;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_MAJ   = 2'd3;

    typedef struct packed {
        logic        action;
        logic [21:0] frame_number;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       overrun;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic       load_bit;
    } lfsr_ctrl_t;

endpackage

/* src/a51_lfsr_unit.sv */
// ----------------------------------------------------------------------------
// a51_lfsr_unit
// The three shift registers, one step per cycle unless ctrl.op is OP_NONE:
// clear, load-and-clock, or majority clock. Gives the post-step keystream bit.
// ----------------------------------------------------------------------------
module a51_lfsr_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  a51_pkg::lfsr_ctrl_t ctrl,
    output logic                ks_bit
);
    import a51_pkg::*;

    logic [R1_W-1:0] r1_reg, r1_next, r1_in;
    logic [R2_W-1:0] r2_reg, r2_next, r2_in;
    logic [R3_W-1:0] r3_reg, r3_next, r3_in;
    logic            a, b, c, m;

    always_comb begin
        r1_in = r1_reg;
        r2_in = r2_reg;
        r3_in = r3_reg;
        if (ctrl.op == OP_LOAD) begin
            r1_in[0] = r1_reg[0] ^ ctrl.load_bit;
            r2_in[0] = r2_reg[0] ^ ctrl.load_bit;
            r3_in[0] = r3_reg[0] ^ ctrl.load_bit;
        end
        a = r1_reg[R1_CLK];
        b = r2_reg[R2_CLK];
        c = r3_reg[R3_CLK];
        m = (a & b) | (a & c) | (b & c);
        r1_next = r1_reg;
        r2_next = r2_reg;
        r3_next = r3_reg;
        case (ctrl.op)
            OP_CLEAR: begin
                r1_next = '0;
                r2_next = '0;
                r3_next = '0;
            end
            OP_LOAD: begin
                r1_next = {r1_in[R1_W-2:0], r1_in[13] ^ r1_in[16] ^ r1_in[17] ^ r1_in[18]};
                r2_next = {r2_in[R2_W-2:0], r2_in[20] ^ r2_in[21]};
                r3_next = {r3_in[R3_W-2:0], r3_in[7] ^ r3_in[20] ^ r3_in[21] ^ r3_in[22]};
            end
            OP_MAJ: begin
                if (a == m) begin
                    r1_next = {r1_reg[R1_W-2:0],
                               r1_reg[13] ^ r1_reg[16] ^ r1_reg[17] ^ r1_reg[18]};
                end
                if (b == m) begin
                    r2_next = {r2_reg[R2_W-2:0], r2_reg[20] ^ r2_reg[21]};
                end
                if (c == m) begin
                    r3_next = {r3_reg[R3_W-2:0],
                               r3_reg[7] ^ r3_reg[20] ^ r3_reg[21] ^ r3_reg[22]};
                end
            end
            default: begin
                r1_next = r1_reg;
            end
        endcase
        ks_bit = r1_next[R1_W-1] ^ r2_next[R2_W-1] ^ r3_next[R3_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_reg <= '0;
            r2_reg <= '0;
            r3_reg <= '0;
        end else begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
        end
    end

endmodule

/* src/a51_sequencer.sv */
// ----------------------------------------------------------------------------
// a51_sequencer
// Steps the shift registers through a frame start: clear, key and frame
// load, warmup. Passes single data steps through when idle.
// ----------------------------------------------------------------------------
module a51_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_go,
    input  logic                data_step,
    input  logic [63:0]         key,
    input  logic [21:0]         frame,
    output logic                busy,
    output a51_pkg::lfsr_ctrl_t ctrl
);
    import a51_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_WARM = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LOAD_BITS-1:0] shift_reg, shift_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        ctrl.op       = OP_NONE;
        ctrl.load_bit = shift_reg[0];
        case (state_reg)
            ST_IDLE: begin
                if (start_go) begin
                    ctrl.op    = OP_CLEAR;
                    shift_next = {frame, key};
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end else if (data_step) begin
                    ctrl.op = OP_MAJ;
                end
            end
            ST_LOAD: begin
                ctrl.op    = OP_LOAD;
                shift_next = {1'b0, shift_reg[LOAD_BITS-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LOAD_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = (WARMUP_CLOCKS == 0) ? ST_IDLE : ST_WARM;
                end
            end
            ST_WARM: begin
                ctrl.op  = OP_MAJ;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WARMUP_CLOCKS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule

/* src/a51_stream_cipher_unit.sv */
// ----------------------------------------------------------------------------
// a51_stream_cipher_unit
// A5/1 keystream unit: frame start with key/frame load and warmup, then one
// majority clock per data item before overrun, keystream bit XORed into bit 0.
// ----------------------------------------------------------------------------
//  channel  ports                      carries
//  s_       s_valid s_ready s_data     start (frame_number) or data byte item
//  m_       m_valid m_ready m_data     out_byte and overrun, data items only
//  cfg      psel penable pwrite paddr  cipher_key at byte address 0, 64 bits
//
//  A data item's result is registered at the next edge after it is accepted.
//  A start item runs clear, then key and frame load, then warmup, with
//  one step of the shared shift register unit per cycle.
//  Reset clears the shift registers, stream position and cipher_key.
//  s_ready drops while a start runs and while a result waits on m_ready.
// ----------------------------------------------------------------------------
module a51_stream_cipher_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  a51_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output a51_pkg::out_item_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [a51_pkg::PADDR_W-1:0] paddr,
    input  logic [a51_pkg::PDATA_W-1:0] pwdata,
    output logic [a51_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import a51_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;
    logic                s_accept, start_go, data_go, data_step, overrun_now;
    logic                busy, ks_bit;
    lfsr_ctrl_t          ctrl;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? '0 : key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[3]) begin
            key_reg <= pwdata;
        end
    end

    assign s_ready = !busy && (!m_valid_reg || m_ready);

    always_comb begin
        s_accept    = s_valid && s_ready;
        start_go    = s_accept && (s_data.action == ACT_START);
        data_go     = s_accept && (s_data.action == ACT_DATA);
        overrun_now = (pos_reg >= POS_W'(KEYSTREAM_LEN));
        data_step   = data_go && !overrun_now;

        pos_next = pos_reg;
        if (start_go) begin
            pos_next = '0;
        end else if (data_step) begin
            pos_next = pos_reg + 1'b1;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (data_go) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = s_data.data_byte ^ {7'b0, ks_bit && !overrun_now};
            m_data_next.overrun  = overrun_now;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    a51_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_go  (start_go),
        .data_step (data_step),
        .key       (key_reg),
        .frame     (s_data.frame_number),
        .busy      (busy),
        .ctrl      (ctrl)
    );

    a51_lfsr_unit u_lfsr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .ks_bit  (ks_bit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/a51_checker.sv */
// ----------------------------------------------------------------------------
// a51_checker
// Port-level checks for the A5/1 keystream unit, bound to the top level.
// ----------------------------------------------------------------------------
module a51_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input a51_pkg::in_item_t           s_data,
    input logic                        m_valid,
    input logic                        m_ready,
    input a51_pkg::out_item_t          m_data,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [a51_pkg::PADDR_W-1:0] paddr,
    input logic [a51_pkg::PDATA_W-1:0] pwdata,
    input logic [a51_pkg::PDATA_W-1:0] prdata,
    input logic                        pready
);
    import a51_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_START |=> !s_ready)
        else $error("ready during frame start");

    a_data_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_DATA |=>
            m_valid && m_data.out_byte[7:1] == $past(s_data.data_byte[7:1]))
        else $error("data item result missing or upper bits altered");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_key_write: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && !paddr[3] |=>
            paddr[3] || prdata == $past(pwdata))
        else $error("cipher_key write not reflected on readback");

endmodule

bind a51_stream_cipher_unit a51_checker u_a51_checker (.*);
